// ===== src/request_retransmit_table_defines.svh =====
// Assertion macros for the request retransmit table.
`ifndef REQUEST_RETRANSMIT_TABLE_DEFINES_SVH
`define REQUEST_RETRANSMIT_TABLE_DEFINES_SVH

// Plain property, sampled on clk, off during reset.
`define RRT_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Same-cycle implication.
`define RRT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`endif

// ===== src/rrt_pkg.sv =====
`default_nettype none
package rrt_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TOUCH_W = 3;

    typedef enum logic [1:0] {
        CMD_SUBMIT = 2'd0,
        CMD_ACK    = 2'd1,
        CMD_FIRE   = 2'd2,
        CMD_MISS   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  request_code;
        logic [15:0] request_id;
        logic [6:0]  attempt_budget;
        logic [2:0]  slot_select;
    } rrt_in_t;

    typedef struct packed {
        logic        send_now;
        logic [7:0]  send_code;
        logic [15:0] send_id;
        logic        stored;
        logic [2:0]  slot_touched;
        logic        released;
    } rrt_out_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic        go;
        cmd_t        cmd;
        logic [7:0]  code;
        logic [15:0] id;
        logic [6:0]  left;
        logic        store_en;
        logic [2:0]  sel;
    } rrt_op_t;

    // Report travelling down the chain
    typedef struct packed {
        logic        send_now;
        logic [7:0]  send_code;
        logic [15:0] send_id;
        logic [2:0]  touched;
        logic        released;
    } rrt_rpt_t;

    typedef struct packed {
        logic     taken;
        rrt_rpt_t rpt;
    } rrt_chain_t;

    function automatic logic [TOUCH_W-1:0] to_touch(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+TOUCH_W-1:0] w;
        w = {{TOUCH_W{1'b0}}, idx};
        return w[TOUCH_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/rrt_cell.sv =====
`default_nettype none
module rrt_cell
    import rrt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SLOT_W-1:0] index,
    input  wire rrt_op_t           op,
    input  wire rrt_chain_t        chain_in,
    output rrt_chain_t             chain_out
);

    logic        valid_reg, valid_next;
    logic [7:0]  code_reg,  code_next;
    logic [15:0] id_reg,    id_next;
    logic [6:0]  left_reg,  left_next;

    logic     match, want, act, last;
    rrt_rpt_t mine;

    assign match = valid_reg && (id_reg == op.id);
    assign last  = (left_reg <= 7'd1);

    always_comb
    begin
        want       = 1'b0;
        valid_next = valid_reg;
        code_next  = code_reg;
        id_next    = id_reg;
        left_next  = left_reg;
        mine       = '0;
        mine.touched = to_touch(index);
        case (op.cmd)
            CMD_SUBMIT:
            begin
                want = !valid_reg && op.store_en;
            end
            CMD_ACK:
            begin
                want          = match;
                mine.released = 1'b1;
            end
            CMD_FIRE:
            begin
                want           = ({{TOUCH_W{1'b0}}, index} == {{SLOT_W{1'b0}}, op.sel});
                mine.send_now  = valid_reg;
                mine.send_code = code_reg;
                mine.send_id   = id_reg;
                mine.released  = valid_reg && last;
            end
            CMD_MISS:
            begin
                want          = match;
                mine.released = last;
            end
            default:
            begin
                want = 1'b0;
            end
        endcase

        act = op.go && want && !chain_in.taken;

        if (act)
        begin
            case (op.cmd)
                CMD_SUBMIT:
                begin
                    valid_next = 1'b1;
                    code_next  = op.code;
                    id_next    = op.id;
                    left_next  = op.left;
                end
                CMD_ACK:
                begin
                    valid_next = 1'b0;
                    left_next  = '0;
                end
                CMD_FIRE, CMD_MISS:
                begin
                    if (valid_reg)
                    begin
                        if (last)
                        begin
                            valid_next = 1'b0;
                            left_next  = '0;
                        end
                        else
                        begin
                            left_next = left_reg - 7'd1;
                        end
                    end
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end

        chain_out.taken = chain_in.taken || (op.go && want);
        chain_out.rpt   = act ? mine : chain_in.rpt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        id_reg   <= id_next;
        left_reg <= left_next;
    end

endmodule
`default_nettype wire

// ===== src/request_retransmit_table.sv =====
// Flow: start is taken only while not busy; op_reg and busy are then registered, and done
//   and rsp are registered from busy. busy is high for the one cycle in which the
//   cell row searches and updates, the priority chain through all slots setting that cycle.
// Reset: rst_n clears every slot's valid mark and the control flags at once; no sweep.
// The receiver cannot stall; done pulses for one cycle and rsp holds till the next result.
`default_nettype none
module request_retransmit_table
    import rrt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire rrt_in_t req,
    output logic         done,
    output rrt_out_t     rsp
);

    // Control: busy marks the evaluation cycle, done the result strobe.
    logic     busy_reg, busy_next;
    logic     done_reg, done_next;
    rrt_op_t  op_reg,   op_next;
    rrt_out_t rsp_reg,  rsp_next;

    logic       accept;
    logic [6:0] budget;

    rrt_chain_t chain [SLOTS+1];

    assign accept = start && !busy_reg;
    // A budget of zero counts as one attempt.
    assign budget = (req.attempt_budget == 7'd0) ? 7'd1 : req.attempt_budget;

    always_comb
    begin
        op_next = op_reg;
        if (accept)
        begin
            op_next.cmd      = cmd_t'(req.cmd);
            op_next.code     = req.request_code;
            op_next.id       = req.request_id;
            op_next.left     = budget - 7'd1;
            op_next.store_en = (budget > 7'd1);
            op_next.sel      = req.slot_select;
        end
        // Cells act only in the evaluation cycle
        op_next.go = accept;
    end

    assign busy_next = accept;
    assign done_next = busy_reg;

    // Row of slot cells; chain[0] carries "nothing claimed yet".
    assign chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        rrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .index     (SLOT_W'(g)),
            .op        (op_reg),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1])
        );
    end

    // Submit always sends the incoming request; other commands report what
    // the acting cell handed down the chain (all zero when none acted).
    always_comb
    begin
        rsp_next = '0;
        if (op_reg.cmd == CMD_SUBMIT)
        begin
            rsp_next.send_now     = 1'b1;
            rsp_next.send_code    = op_reg.code;
            rsp_next.send_id      = op_reg.id;
            rsp_next.stored       = chain[SLOTS].taken;
            rsp_next.slot_touched = chain[SLOTS].rpt.touched;
        end
        else
        begin
            rsp_next.send_now     = chain[SLOTS].rpt.send_now;
            rsp_next.send_code    = chain[SLOTS].rpt.send_now ? chain[SLOTS].rpt.send_code : 8'd0;
            rsp_next.send_id      = chain[SLOTS].rpt.send_now ? chain[SLOTS].rpt.send_id : 16'd0;
            rsp_next.slot_touched = chain[SLOTS].rpt.touched;
            rsp_next.released     = chain[SLOTS].rpt.released;
        end
    end

    // The operation register holds the go flag, so it is cleared with the
    // other control state: no stray operation runs after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire

// ===== src/rrt_checker.sv =====
`default_nettype none
`include "request_retransmit_table_defines.svh"
module rrt_checker
    import rrt_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     done,
    input wire rrt_out_t rsp
);

    `RRT_ASSERT(a_take_goes_busy, start && !busy |=> busy && !done)
    `RRT_ASSERT(a_busy_gives_done, busy |=> done && !busy)
    `RRT_ASSERT_IMP(a_done_not_busy, done, !busy)
    `RRT_ASSERT_IMP(a_quiet_payload, done && !rsp.send_now, rsp.send_code == 8'd0 && rsp.send_id == 16'd0)
    `RRT_ASSERT_IMP(a_store_sends, done && rsp.stored, rsp.send_now && !rsp.released)

endmodule

bind request_retransmit_table rrt_checker u_rrt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
`default_nettype wire
